// ----- rtl/core/csrspmv_pkg.sv -----
// ----------------------------------------------------------------------------
// CSR sparse matrix-vector core package
// Field widths, operation codes and the control bundle passed between stages.
// ----------------------------------------------------------------------------
package csrspmv_pkg;

    localparam int OP_W  = 2;
    localparam int COL_W = 14;
    localparam int VAL_W = 32;
    localparam int ROW_W = 14;
    localparam int SUM_W = 64;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_MAC   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLOSE = 2'd2;

    typedef struct packed {
        logic valid;
        logic emit;
    } t_term_ctrl;

endpackage

// ----- rtl/core/csrspmv_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read returns the old contents.
// ----------------------------------------------------------------------------
module csrspmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/csrspmv_mac.sv -----
// ----------------------------------------------------------------------------
// CSR sparse matrix-vector multiply-accumulate stage
// Registers the term product, adds it to the row sum and holds finished rows
// in an output register.
// ----------------------------------------------------------------------------
module csrspmv_mac
    import csrspmv_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_term_ctrl              i_term,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic signed [VAL_W-1:0] i_elem,
    output logic                    o_ready,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [ROW_W-1:0]        o_row_index,
    output logic signed [SUM_W-1:0] o_row_sum
);

    logic                    r_s2_valid;
    logic                    r_s2_emit;
    logic signed [SUM_W-1:0] r_s2_prod;
    logic [SUM_W-1:0]        r_acc;
    logic [SUM_W-1:0]        n_acc;
    logic [ROW_W-1:0]        r_row_cnt;
    logic [ROW_W-1:0]        n_row_cnt;
    logic                    r_out_valid;
    logic [ROW_W-1:0]        r_out_row;
    logic [SUM_W-1:0]        r_out_sum;
    logic [SUM_W-1:0]        acc_sum;
    logic                    out_free;
    logic                    s2_go;
    logic                    s2_ready;

    assign out_free = !r_out_valid || i_out_ready;
    assign s2_go    = r_s2_valid && (!r_s2_emit || out_free);
    assign s2_ready = !r_s2_valid || s2_go;
    assign acc_sum  = r_acc + SUM_W'(r_s2_prod);

    always_comb begin
        n_acc     = r_acc;
        n_row_cnt = r_row_cnt;
        if (s2_go) begin
            if (r_s2_emit) begin
                n_acc     = '0;
                n_row_cnt = r_row_cnt + 1'b1;
            end else begin
                n_acc = acc_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_s2_emit   <= 1'b0;
            r_acc       <= '0;
            r_row_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s2_ready) begin
                r_s2_valid <= i_term.valid;
                r_s2_emit  <= i_term.emit;
            end
            r_acc     <= n_acc;
            r_row_cnt <= n_row_cnt;
            if (s2_go && r_s2_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && i_term.valid) begin
            r_s2_prod <= SUM_W'(i_value) * SUM_W'(i_elem);
        end
        if (s2_go && r_s2_emit) begin
            r_out_sum <= acc_sum;
            r_out_row <= r_row_cnt;
        end
    end

    assign o_ready     = s2_ready;
    assign o_out_valid = r_out_valid;
    assign o_row_index = r_out_row;
    assign o_row_sum   = r_out_sum;

`ifndef NO_ASSERTIONS
    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_go && r_s2_emit) |=> (r_acc == '0))
        else $error("row sum not cleared after a row was closed");

    a_row_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_go && r_s2_emit) |=> (r_row_cnt == ROW_W'(o_row_index + 1'b1)))
        else $error("row counter out of step with the emitted row");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("pending result dropped before its transfer");
`endif

endmodule

// ----- rtl/core/csr_sparse_matrix_vector_multiply_core.sv -----
// A row's result passes the read stage, product register and output register in order.
// Throughput: one item per cycle when no stall holds the input, set by the single vector
// RAM read and one multiplier; the RAM write and the product register keep that rate.
// Reset clears the row sum, the row counter and all valid flags; vector RAM is not cleared.
// ----------------------------------------------------------------------------
// CSR sparse matrix-vector multiply core
// Loads a dense vector into on-chip RAM and accumulates nonzero terms per row.
// ----------------------------------------------------------------------------
module csr_sparse_matrix_vector_multiply_core
    import csrspmv_pkg::*;
#(
    parameter int VECTOR_DEPTH = 16384
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [OP_W-1:0]         i_op,
    input  logic [COL_W-1:0]        i_column,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_row_end,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [ROW_W-1:0]        o_row_index,
    output logic signed [SUM_W-1:0] o_row_sum
);

    localparam int ADDR_W = $clog2(VECTOR_DEPTH);
    localparam int CMP_W  = (ADDR_W + 1 > COL_W) ? ADDR_W + 1 : COL_W;

    logic                    in_xfer;
    logic                    in_range;
    logic [ADDR_W-1:0]       addr;
    logic                    s2_ready;
    logic [VAL_W-1:0]        rdata;
    logic                    r_s1_valid;
    logic                    r_s1_emit;
    logic                    r_s1_use;
    logic signed [VAL_W-1:0] r_s1_value;
    logic signed [VAL_W-1:0] elem;
    t_term_ctrl              term;

    assign o_in_ready = !r_s1_valid || s2_ready;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign in_range   = CMP_W'(i_column) < CMP_W'(VECTOR_DEPTH);
    assign addr       = ADDR_W'(i_column);

    csrspmv_ram #(
        .WIDTH (VAL_W),
        .DEPTH (VECTOR_DEPTH)
    ) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (in_xfer && (i_op == OP_LOAD) && in_range),
        .i_waddr (addr),
        .i_wdata (i_value),
        .i_re    (in_xfer && (i_op == OP_MAC)),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_emit  <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= in_xfer && ((i_op == OP_MAC) || (i_op == OP_CLOSE));
            r_s1_emit  <= (i_op == OP_CLOSE) || ((i_op == OP_MAC) && i_row_end);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_value <= i_value;
            r_s1_use   <= (i_op == OP_MAC) && in_range;
        end
    end

    assign elem       = r_s1_use ? $signed(rdata) : '0;
    assign term.valid = r_s1_valid;
    assign term.emit  = r_s1_emit;

    csrspmv_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_term      (term),
        .i_value     (r_s1_value),
        .i_elem      (elem),
        .o_ready     (s2_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_row_index (o_row_index),
        .o_row_sum   (o_row_sum)
    );

`ifndef NO_ASSERTIONS
    a_term_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && ((i_op == OP_MAC) || (i_op == OP_CLOSE))) |=> r_s1_valid)
        else $error("accepted term did not enter the read stage");

    a_s1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s2_ready) |=> (r_s1_valid && $stable(r_s1_emit) && $stable(rdata)))
        else $error("stalled read stage lost its term");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_row_index) && $stable(o_row_sum)))
        else $error("waiting result changed before its transfer");
`endif

endmodule
